// ----- rtl/mvns_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and waveform helpers for the multi-voice note synth.
// No dependencies; the synth, its registers and the testbench import this package.
package mvns_pkg;

  localparam int VOICES     = 4;
  localparam int NOTES      = 256;
  localparam int CHUNK_LEN  = 256;
  localparam int VOICE_W    = $clog2(VOICES);
  localparam int NOTE_W     = $clog2(NOTES);
  localparam int ADDR_W     = VOICE_W + NOTE_W;
  localparam int CHUNK_W    = $clog2(CHUNK_LEN + 1);
  localparam int CNT_W      = 9;
  localparam int WAVE_W     = 2;
  localparam int VOL_W      = 5;
  localparam int PADDR_W    = 6;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_VOICES_ON   = 3'd0,
    REG_SONG_LENGTH = 3'd1,
    REG_WAVEFORMS   = 3'd2,
    REG_VOLUMES     = 3'd3,
    REG_NOTE_COUNTS = 3'd4
  } reg_idx_t;

  localparam logic [1:0] WAVE_TRI = 2'd1;
  localparam logic [1:0] WAVE_SQR = 2'd2;

  typedef struct packed {
    logic [2:0]  voices_on;
    logic [31:0] song_length;
    logic [7:0]  voice_waveforms;
    logic [19:0] voice_volumes;
    logic [35:0] note_counts;
  } cfg_t;

  // Maps a phase to the selected waveform; codes other than triangle and
  // square give the saw, which is the phase itself.
  function automatic logic [31:0] shape(input logic [31:0] x, input logic [1:0] wave);
    logic [31:0] r;
    r = x;
    if (wave == WAVE_TRI) begin
      if (x[31]) r = (x + 32'h3fff_ffff) << 1;
      else       r = 32'h7fff_ffff - (x << 1);
    end else if (wave == WAVE_SQR) begin
      r = (!x[31] && x != 32'd0) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

// ----- rtl/mvns_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for note items and mixed samples.
// Depends on nothing but plain logic types.
interface mvns_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  operation;
  logic [1:0]  voice_index;
  logic [7:0]  note_index;
  logic [31:0] note_start;
  logic [31:0] note_step;
  modport source (output valid, operation, voice_index, note_index, note_start,
                  note_step, input ready);
  modport sink   (input valid, operation, voice_index, note_index, note_start,
                  note_step, output ready);
endinterface

interface mvns_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] mixed_sample;
  logic [31:0] sample_time;
  modport source (output valid, mixed_sample, sample_time, input ready);
  modport sink   (input valid, mixed_sample, sample_time, output ready);
endinterface

// ----- rtl/multi_voice_note_synth.sv -----
`timescale 1ns / 1ps
// Multi-voice phase-accumulator synth: top level with note memory and sequencer.
// Depends on mvns_pkg, mvns_if and mvns_regs.
//
// Usage: in_ch carries load items (operation 0), which write one entry of a
// voice's note table in the cycle they transfer, and tick items (operation 1),
// each of which yields one transfer on out_ch carrying the mixed sample and
// the song time it belongs to. A load gives no result. A tick walks the
// voices in use; for each it scans the note table downward from the voice's
// last note in use, each note passing through a memory read state (S_RD)
// and a compare state (S_CHK), then mixes and advances the phase. The
// result sits in an output register, so the next item may enter while it
// waits; a tick finishing while that register is still full waits until
// out_ch takes the old sample.
// Reset (rst_n low, synchronous) zeroes phases, song time and chunk
// position and loads the register defaults; the note tables are undefined
// until written, and no clearing pass runs.
module multi_voice_note_synth (
  input  logic                         clk,
  input  logic                         rst_n,
  mvns_in_if.sink                      in_ch,
  mvns_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvns_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import mvns_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  cfg_t cfg;

  mvns_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t             state_r, state_nxt;
  logic [VOICE_W-1:0] voice_r, voice_nxt;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [31:0]        mix_r, mix_nxt;
  logic [31:0]        time_r, time_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [31:0]        phase_r [VOICES];
  logic               out_valid_r;
  logic [31:0]        out_mix_r, out_time_r;

  logic [63:0]        mem [VOICES*NOTES];
  logic [63:0]        rd_data_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr;

  logic [VOICE_W-1:0] last_voice;
  logic               in_xfer, out_free, phase_we;
  logic [31:0]        start_w, step_w, ph, shaped, next_time;
  logic [VOL_W-1:0]   vol;
  logic [WAVE_W-1:0]  wave;

  // Index of the top note in use for a voice, clamped to 1..NOTES notes.
  function automatic logic [NOTE_W-1:0] top_note(input logic [35:0] counts,
                                                 input logic [VOICE_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = counts[CNT_W*v +: CNT_W];
    if (c == '0) return '0;
    if (32'(c) > NOTES) return NOTE_W'(NOTES - 1);
    return NOTE_W'(c - 1'b1);
  endfunction

  always_comb begin
    if (cfg.voices_on == '0)         last_voice = '0;
    else if (32'(cfg.voices_on) > VOICES) last_voice = VOICE_W'(VOICES - 1);
    else                             last_voice = VOICE_W'(cfg.voices_on - 1'b1);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign mem_we    = in_xfer && (in_ch.operation == OP_LOAD);
  assign mem_waddr = {in_ch.voice_index, in_ch.note_index};
  assign mem_re    = (state_r == S_RD);

  // Loads are taken only in idle, so a write never overlaps a tick's scan.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= {in_ch.note_start, in_ch.note_step};
    if (mem_re) rd_data_r <= mem[{voice_r, note_r}];
  end

  assign start_w   = rd_data_r[63:32];
  assign step_w    = rd_data_r[31:0];
  assign ph        = phase_r[voice_r];
  assign wave      = cfg.voice_waveforms[WAVE_W*voice_r +: WAVE_W];
  assign vol       = cfg.voice_volumes[VOL_W*voice_r +: VOL_W];
  assign shaped    = shape(ph, wave);
  assign next_time = time_r + 32'd1;

  always_comb begin
    state_nxt = state_r;
    voice_nxt = voice_r;
    note_nxt  = note_r;
    mix_nxt   = mix_r;
    time_nxt  = time_r;
    chunk_nxt = chunk_r;
    phase_we  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_ch.operation == OP_TICK) begin
          voice_nxt = '0;
          note_nxt  = top_note(cfg.note_counts, '0);
          mix_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (note_r != '0 && start_w > time_r) begin
          note_nxt  = note_r - 1'b1;
          state_nxt = S_RD;
        end else begin
          phase_we = 1'b1;
          mix_nxt  = mix_r + 32'($signed(shaped) >>> vol);
          if (voice_r == last_voice) begin
            state_nxt = S_DONE;
          end else begin
            voice_nxt = voice_r + 1'b1;
            note_nxt  = top_note(cfg.note_counts, voice_r + 1'b1);
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          time_nxt  = next_time;
          chunk_nxt = chunk_r + 1'b1;
          if (chunk_r == CHUNK_W'(CHUNK_LEN - 1)) begin
            chunk_nxt = '0;
            if (next_time > cfg.song_length) time_nxt = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      voice_r     <= '0;
      note_r      <= '0;
      mix_r       <= '0;
      time_r      <= '0;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) phase_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      voice_r <= voice_nxt;
      note_r  <= note_nxt;
      mix_r   <= mix_nxt;
      time_r  <= time_nxt;
      chunk_r <= chunk_nxt;
      if (phase_we) phase_r[voice_r] <= ph + step_w;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_mix_r  <= mix_r;
      out_time_r <= time_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mixed_sample = out_mix_r;
  assign out_ch.sample_time  = out_time_r;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input accepted while a tick is in progress");

  a_voice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (voice_r <= last_voice))
    else $error("scan reached a voice that is not in use");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished tick did not load the output register");

  a_read_before_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> $past(state_r == S_RD))
    else $error("note compared without a fresh memory read");

endmodule

// ----- rtl/mvns_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers of the synth.
// Depends on mvns_pkg.
module mvns_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvns_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output mvns_pkg::cfg_t              cfg
);
  import mvns_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voices_on       <= 3'd1;
      cfg_r.song_length     <= '0;
      cfg_r.voice_waveforms <= '0;
      cfg_r.voice_volumes   <= '0;
      cfg_r.note_counts     <= 36'd134480385;
    end else if (wr_en) begin
      unique case (idx)
        REG_VOICES_ON:   cfg_r.voices_on       <= pwdata[2:0];
        REG_SONG_LENGTH: cfg_r.song_length     <= pwdata[31:0];
        REG_WAVEFORMS:   cfg_r.voice_waveforms <= pwdata[7:0];
        REG_VOLUMES:     cfg_r.voice_volumes   <= pwdata[19:0];
        REG_NOTE_COUNTS: cfg_r.note_counts     <= pwdata[35:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOICES_ON:   prdata = {61'd0, cfg_r.voices_on};
      REG_SONG_LENGTH: prdata = {32'd0, cfg_r.song_length};
      REG_WAVEFORMS:   prdata = {56'd0, cfg_r.voice_waveforms};
      REG_VOLUMES:     prdata = {44'd0, cfg_r.voice_volumes};
      REG_NOTE_COUNTS: prdata = {28'd0, cfg_r.note_counts};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- tb/multi_voice_note_synth_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multi_voice_note_synth: directed note loads and ticks,
// then random songs checked by a behavioral predictor; needs mvns_pkg, mvns_if and the DUT.
module multi_voice_note_synth_test;
  import mvns_pkg::*;

  localparam int NSLOTS = VOICES * NOTES;

  typedef struct packed {
    op_t         operation;
    logic [1:0]  voice_index;
    logic [7:0]  note_index;
    logic [31:0] note_start;
    logic [31:0] note_step;
  } note_item_t;

  typedef struct packed {
    logic [31:0] mixed_sample;
    logic [31:0] sample_time;
  } sample_t;

  typedef struct {
    note_item_t  item;
    logic        known;
    logic [31:0] mixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  mvns_in_if  in_ch ();
  mvns_out_if out_ch ();

  multi_voice_note_synth i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [31:0] start_tbl [NSLOTS];
  logic [31:0] step_tbl [NSLOTS];
  bit          written [NSLOTS];
  logic [31:0] phase_acc [VOICES];
  logic [31:0] song_now;
  int unsigned chunk_pos;
  cfg_t        cfg;

  sample_t     pending_samples[$];
  logic        pending_known[$];
  logic [31:0] pending_fixed[$];
  int          errors = 0;
  int          samples_seen = 0;
  int          loads_sent = 0;
  bit          hold_long = 1'b0;

  function automatic int unsigned voices_used();
    int unsigned n;
    n = cfg.voices_on;
    if (n < 1) n = 1;
    if (n > VOICES) n = VOICES;
    return n;
  endfunction

  function automatic int unsigned notes_used(int unsigned v);
    int unsigned c;
    c = cfg.note_counts[v*CNT_W +: CNT_W];
    if (c < 1) c = 1;
    if (c > NOTES) c = NOTES;
    return c;
  endfunction

  function automatic logic [31:0] wave_of(logic [31:0] x, logic [1:0] w);
    logic [31:0] r;
    r = x;
    if (w == WAVE_TRI) begin
      if (x[31]) r = (x + 32'h3fff_ffff) << 1;
      else r = 32'h7fff_ffff - (x << 1);
    end else if (w == WAVE_SQR) begin
      r = (!x[31] && x != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    return r;
  endfunction

  // Advances the predictor by one accepted item and queues any sample it yields.
  task automatic predict_item(note_item_t it, logic known, logic [31:0] fixed);
    int unsigned n, b;
    logic [31:0] mix;
    sample_t s;
    mix = '0;
    if (it.operation == OP_LOAD) begin
      b = it.voice_index * NOTES + it.note_index;
      start_tbl[b] = it.note_start;
      step_tbl[b] = it.note_step;
      written[b] = 1'b1;
      return;
    end
    for (int unsigned v = 0; v < voices_used(); v++) begin
      b = v * NOTES;
      n = notes_used(v) - 1;
      while (n != 0 && start_tbl[b+n] > song_now) n--;
      mix += $unsigned($signed(wave_of(phase_acc[v], cfg.voice_waveforms[v*WAVE_W +: WAVE_W]))
                       >>> cfg.voice_volumes[v*VOL_W +: VOL_W]);
      phase_acc[v] += step_tbl[b+n];
    end
    s.mixed_sample = mix;
    s.sample_time = song_now;
    pending_samples.push_back(s);
    pending_known.push_back(known);
    pending_fixed.push_back(fixed);
    song_now += 1;
    chunk_pos++;
    if (chunk_pos >= CHUNK_LEN) begin
      chunk_pos = 0;
      if (song_now > cfg.song_length) song_now = 0;
    end
  endtask

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(idx * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_VOICES_ON:   cfg.voices_on = val[2:0];
      REG_SONG_LENGTH: cfg.song_length = val[31:0];
      REG_WAVEFORMS:   cfg.voice_waveforms = val[7:0];
      REG_VOLUMES:     cfg.voice_volumes = val[19:0];
      REG_NOTE_COUNTS: cfg.note_counts = val[35:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // With no gap, valid stays high and the next item follows back to back.
  task automatic send_item(note_item_t it, logic known = 1'b0, logic [31:0] fixed = '0);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.voice_index <= it.voice_index;
    in_ch.note_index <= it.note_index;
    in_ch.note_start <= it.note_start;
    in_ch.note_step <= it.note_step;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it, known, fixed);
    if (it.operation == OP_LOAD) loads_sent++;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic note_item_t load_item(int v, int n, logic [31:0] st, logic [31:0] sp);
    note_item_t it;
    it.operation = OP_LOAD; it.voice_index = 2'(v); it.note_index = 8'(n);
    it.note_start = st; it.note_step = sp;
    return it;
  endfunction

  function automatic note_item_t tick_item();
    note_item_t it;
    it.operation = OP_TICK;
    it.voice_index = 2'($urandom); it.note_index = 8'($urandom);
    it.note_start = $urandom; it.note_step = $urandom;
    return it;
  endfunction

  // Fills the slots that the current note counts can reach, mostly with sorted start times.
  task automatic load_song(int unsigned maxn);
    logic [31:0] t;
    for (int v = 0; v < VOICES; v++) begin
      t = $urandom_range(0, 3);
      for (int n = 0; n < maxn; n++) begin
        send_item(load_item(v, n, ($urandom_range(0, 9) == 0) ? $urandom : t, $urandom));
        t += $urandom_range(0, 40);
      end
    end
  endtask

  // Receiver: checks each sample transfer and stalls at random.
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample transfer: mixed_sample %h", out_ch.mixed_sample);
        errors++;
      end else begin
        exp_s = pending_samples.pop_front();
        if (pending_known.pop_front() && pending_fixed[0] != exp_s.mixed_sample) begin
          $error("table value mismatch: mixed_sample expected %h predicted %h",
                 pending_fixed[0], exp_s.mixed_sample);
          errors++;
        end
        void'(pending_fixed.pop_front());
        if (out_ch.mixed_sample !== exp_s.mixed_sample) begin
          $error("mixed_sample expected %h actual %h", exp_s.mixed_sample, out_ch.mixed_sample);
          errors++;
        end
        if (out_ch.sample_time !== exp_s.sample_time) begin
          $error("sample_time expected %h actual %h", exp_s.sample_time, out_ch.sample_time);
          errors++;
        end
      end
    end
    if (hold_long) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 3) == 0 && samples_seen % 40 < 10);
  end

  // Long hold-off of the receiver, counted in cycles here.
  initial begin
    wait (samples_seen > 200);
    hold_long = 1'b1;
    repeat (400) @(posedge clk);
    hold_long = 1'b0;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int unsigned maxn;
    in_ch.valid = 1'b0; in_ch.operation = OP_LOAD; in_ch.voice_index = '0;
    in_ch.note_index = '0; in_ch.note_start = '0; in_ch.note_step = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NSLOTS; i++) begin
      start_tbl[i] = '0; step_tbl[i] = '0; written[i] = 1'b0;
    end
    for (int v = 0; v < VOICES; v++) phase_acc[v] = '0;
    song_now = '0; chunk_pos = 0;
    cfg.voices_on = 3'd1; cfg.song_length = '0; cfg.voice_waveforms = '0;
    cfg.voice_volumes = '0; cfg.note_counts = 36'd134480385;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults and saw extremes.
    rows.push_back('{load_item(0, 0, 32'h0, 32'h8000_0000), 1'b0, '0});
    rows.push_back('{load_item(3, 255, 32'hffff_ffff, 32'hffff_ffff), 1'b0, '0});
    rows.push_back('{tick_item(), 1'b1, 32'h0});
    rows.push_back('{tick_item(), 1'b1, 32'h8000_0000});
    rows.push_back('{tick_item(), 1'b1, 32'h0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].mixed);
    drain();

    // Four voices, single-note tables, every waveform, widest volume fields.
    reg_write(REG_VOICES_ON, 64'd7);
    reg_write(REG_NOTE_COUNTS, 64'h0_0000_0000);
    reg_write(REG_WAVEFORMS, 64'b11_10_01_00);
    reg_write(REG_VOLUMES, 64'hfffff);
    reg_write(REG_SONG_LENGTH, 64'hffff_ffff);
    for (int v = 0; v < VOICES; v++) begin
      send_item(load_item(v, 0, 32'h0, 32'h4000_0000));
      send_item(load_item(v, 1, 32'h1, 32'hc000_0001));
    end
    repeat (6) send_item(tick_item());
    drain();
    reg_write(REG_VOLUMES, 64'h0);
    reg_write(REG_NOTE_COUNTS, {28'h0, 9'd2, 9'd2, 9'd2, 9'd2});
    repeat (10) send_item(tick_item());
    drain();

    // Random phases: mostly well-formed songs with small note counts.
    for (int ph = 0; ph < 6; ph++) begin
      maxn = (ph == 5) ? NOTES : $urandom_range(1, 12);
      reg_write(REG_VOICES_ON, (ph == 0) ? 64'd0 :
                               (ph == 5) ? 64'd1 : 64'($urandom_range(1, 7)));
      reg_write(REG_SONG_LENGTH, (ph % 2) ? 64'($urandom_range(0, 300)) : 64'($urandom));
      reg_write(REG_WAVEFORMS, 64'($urandom_range(0, 255)));
      reg_write(REG_VOLUMES, 64'($urandom_range(0, 20'hfffff)));
      reg_write(REG_NOTE_COUNTS, {28'h0,
        9'($urandom_range(0, maxn)), 9'($urandom_range(0, maxn)),
        9'($urandom_range(0, maxn)), 9'($urandom_range(1, maxn))});
      if (ph == 5) begin
        // Only one voice and a few ticks at full table depth: each scans many notes.
        for (int n = 0; n < NOTES; n++)
          if (!written[n]) send_item(load_item(0, n, $urandom, $urandom));
        repeat (8) send_item(tick_item());
      end else begin
        load_song(maxn);
        repeat (100) begin
          if ($urandom_range(0, 9) == 0)
            send_item(load_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom,
                                $urandom));
          else
            send_item(tick_item());
        end
      end
      drain();
    end

    $display("Covered %0d sample transfers and %0d note loads across several register settings.",
             samples_seen, loads_sent);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
